### rtl/itm_pkg.sv
// Shared constants, codes and control types of the triangular Ising Metropolis block.
`default_nettype none
package itm_pkg;

    // Lattice geometry and random precision.
    localparam int LAT_W       = 32;
    localparam int LAT_H       = 32;
    localparam int RANDOM_BITS = 16;

    localparam int SITE_COUNT = LAT_W * LAT_H;
    localparam int ADDR_W     = $clog2(SITE_COUNT);
    localparam int XW         = $clog2(LAT_W);
    localparam int YW         = $clog2(LAT_H);

    // Field widths.
    localparam int SITE_W    = 10;
    localparam int RND_W     = 16;
    localparam int THR_W     = 17;
    localparam int MAG_W     = 12;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 16;

    localparam int NBR_COUNT  = 6;
    localparam int FLIP_LIMIT = NBR_COUNT / 2;

    localparam logic [RND_W-1:0] RND_MASK = (RANDOM_BITS >= RND_W) ? {RND_W{1'b1}} :
                                            RND_W'((64'd1 << RANDOM_BITS) - 64'd1);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);
    localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(SITE_COUNT);
    localparam logic [MAG_W-1:0] MAG_STEP  = MAG_W'(2);

    // Row index by reciprocal multiply: exact for every site below 2**SITE_W.
    localparam int DIV_SHIFT = SITE_W + $clog2(LAT_W);
    localparam int RCP_W     = SITE_W + 1;
    localparam int PROD_W    = SITE_W + RCP_W;
    localparam logic [RCP_W-1:0] DIV_RECIP = RCP_W'((2 ** DIV_SHIFT + LAT_W - 1) / LAT_W);

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_TRIAL = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR_LOW  = 2'd0,
        CFG_THR_MID  = 2'd1,
        CFG_THR_HIGH = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SEL_SELF      = 3'd0,
        SEL_LEFT      = 3'd1,
        SEL_RIGHT     = 3'd2,
        SEL_UP        = 3'd3,
        SEL_DOWN      = 3'd4,
        SEL_UPLEFT    = 3'd5,
        SEL_DOWNRIGHT = 3'd6
    } fetch_sel_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_COORD,
        ST_FETCH,
        ST_WAIT,
        ST_UPDATE,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       div;
        logic       coord;
        logic       rd_en;
        fetch_sel_t rd_sel;
        logic       update;
        logic       push;
        logic       clr_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_trial;
        logic clr_done;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

### rtl/ising_triangular_metropolis.sv
// Top level of the triangular-lattice Ising Metropolis update block.
//
// Requests enter on the s_ stream: tuser carries the request kind (write, flip trial,
// read; the unused code reads) and tdata the site, spin to write and random fraction.
// Every request gives one result on the m_ stream: the spin at the site afterwards,
// whether a trial flipped it, and the magnetization after the request.
// Thresholds for the three positive energy cases are written on the cfg_ channel,
// index 0 to 2, and apply to any update after they are registered; cfg_ready is always high.
// The spins live in a single-port-read RAM, so a trial reads its own spin and its six
// neighbors one per cycle, a write or read fetches only the spin of the site itself,
// and a request for a site outside the lattice reads no spin at all.
// One request is in flight at a time; s_tready returns in the cycle the result is
// registered, so the next request may enter while that result waits on m_tready.
// If m_tready stays low, the next result holds until the output register is free.
// After reset every spin is set up by a clearing pass during which s_tready is low;
// thresholds reset to 65536.
`default_nettype none
module ising_triangular_metropolis
    import itm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // site[9:0], spin_value[10], random_u[26:11]
    input  wire logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // site_spin[0], flipped[1], magnetization[13:2]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]     cfg_data
);

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic              ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic              ram_rd_data;

    assign cfg_ready = 1'b1;

    itm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

    itm_ram #(
        .WIDTH (1),
        .DEPTH (SITE_COUNT)
    ) u_spin_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule
`default_nettype wire

### rtl/itm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module itm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/itm_ctrl.sv
// Controller state machine: sequences clearing, coordinate split, fetches and update.
`default_nettype none
module itm_ctrl
    import itm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       last_fetch;

    // A write or read request only needs the spin of the site itself.
    assign last_fetch = !status.is_trial || (cnt_reg == 3'(SEL_DOWNRIGHT));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_COORD;
            end
            ST_COORD:
            begin
                cnt_next   = 3'd0;
                state_next = status.in_range ? ST_FETCH : ST_UPDATE;
            end
            ST_FETCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (last_fetch)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = fetch_sel_t'(cnt_reg);
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:  cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIV:    cmd.div = 1'b1;
            ST_COORD:  cmd.coord = 1'b1;
            ST_FETCH:  cmd.rd_en = 1'b1;
            ST_WAIT:   cmd.rd_en = 1'b0;
            ST_UPDATE: cmd.update = 1'b1;
            ST_PUSH:   cmd.push = status.out_free;
            default:   cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

### rtl/itm_datapath.sv
// Datapath: request registers, neighbor addressing, flip decision, totals and result register.
`default_nettype none
module itm_datapath
    import itm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    output dp_status_t                status,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic [REQ_W-1:0]     s_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]     cfg_data,
    output logic                      ram_wr_en,
    output logic [ADDR_W-1:0]         ram_wr_addr,
    output logic                      ram_wr_data,
    output logic                      ram_rd_en,
    output logic [ADDR_W-1:0]         ram_rd_addr,
    input  wire logic                 ram_rd_data,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [M_DATA_W-1:0]       m_tdata
);

    // Request payload.
    logic [REQ_W-1:0]  req_reg;
    logic [SITE_W-1:0] site_reg;
    logic              val_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic              in_range_reg;
    logic [YW-1:0]     y_reg;
    logic [XW-1:0]     x_reg;
    logic              own_reg;
    logic [2:0]        ups_reg;
    logic [2:0]        ups_next;
    fetch_sel_t        rd_tag_reg;
    logic              rd_vld_reg;
    logic              res_spin_reg;
    logic              res_flip_reg;
    logic              out_spin_reg;
    logic              out_flip_reg;
    logic [MAG_W-1:0]  out_mag_reg;

    // Control and configuration state.
    logic [THR_W-1:0]  thr_low_reg;
    logic [THR_W-1:0]  thr_low_next;
    logic [THR_W-1:0]  thr_mid_reg;
    logic [THR_W-1:0]  thr_mid_next;
    logic [THR_W-1:0]  thr_high_reg;
    logic [THR_W-1:0]  thr_high_next;
    logic [MAG_W-1:0]  total_reg;
    logic [MAG_W-1:0]  total_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;

    logic [PROD_W-1:0] row_prod;
    logic [SITE_W-1:0] row_base;
    logic [XW-1:0]     x_dec;
    logic [XW-1:0]     x_inc;
    logic [YW-1:0]     y_dec;
    logic [YW-1:0]     y_inc;
    logic [XW-1:0]     x_sel;
    logic [YW-1:0]     y_sel;
    logic              is_trial;
    logic              is_write;
    logic [2:0]        aligned;
    logic [RND_W:0]    rnd_ext;
    logic              flip_ok;
    logic              do_flip;
    logic              new_spin;

    assign is_trial = (req_reg == REQ_TRIAL);
    assign is_write = (req_reg == REQ_WRITE);

    assign row_prod = PROD_W'(site_reg) * PROD_W'(DIV_RECIP);
    assign row_base = SITE_W'(SITE_W'(y_reg) * SITE_W'(LAT_W));

    // Periodic wrap of the coordinates.
    assign x_dec = (x_reg == '0) ? XW'(LAT_W - 1) : x_reg - XW'(1);
    assign x_inc = (x_reg == XW'(LAT_W - 1)) ? '0 : x_reg + XW'(1);
    assign y_dec = (y_reg == '0) ? YW'(LAT_H - 1) : y_reg - YW'(1);
    assign y_inc = (y_reg == YW'(LAT_H - 1)) ? '0 : y_reg + YW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            SEL_SELF:      begin x_sel = x_reg; y_sel = y_reg; end
            SEL_LEFT:      begin x_sel = x_dec; y_sel = y_reg; end
            SEL_RIGHT:     begin x_sel = x_inc; y_sel = y_reg; end
            SEL_UP:        begin x_sel = x_reg; y_sel = y_dec; end
            SEL_DOWN:      begin x_sel = x_reg; y_sel = y_inc; end
            SEL_UPLEFT:    begin x_sel = x_dec; y_sel = y_dec; end
            SEL_DOWNRIGHT: begin x_sel = x_inc; y_sel = y_inc; end
            default:       begin x_sel = x_reg; y_sel = y_reg; end
        endcase
    end

    assign ram_rd_en   = cmd.rd_en;
    assign ram_rd_addr = ADDR_W'(x_sel) + ADDR_W'(y_sel) * ADDR_W'(LAT_W);

    // Count of neighbors aligned with the site spin; spin times sum is 2*aligned - 6,
    // so the energy never rises for three or fewer aligned neighbors.
    assign aligned = own_reg ? ups_reg : 3'(NBR_COUNT) - ups_reg;
    assign rnd_ext = {1'b0, rnd_reg};

    always_comb
    begin
        if (aligned <= 3'(FLIP_LIMIT))
        begin
            flip_ok = 1'b1;
        end
        else if (aligned == 3'(FLIP_LIMIT + 1))
        begin
            flip_ok = rnd_ext < thr_low_reg;
        end
        else if (aligned == 3'(FLIP_LIMIT + 2))
        begin
            flip_ok = rnd_ext < thr_mid_reg;
        end
        else
        begin
            flip_ok = rnd_ext < thr_high_reg;
        end
    end

    assign do_flip  = is_trial && flip_ok;
    assign new_spin = is_write ? val_reg : (do_flip ? ~own_reg : own_reg);

    assign ram_wr_en   = cmd.clr_step || (cmd.update && in_range_reg && (is_write || do_flip));
    assign ram_wr_addr = cmd.clr_step ? clr_addr_reg : ADDR_W'(site_reg);
    assign ram_wr_data = cmd.clr_step ? 1'b1 : new_spin;

    always_comb
    begin
        ups_next = ups_reg;
        if (cmd.load)
        begin
            ups_next = 3'd0;
        end
        else if (rd_vld_reg && (rd_tag_reg != SEL_SELF) && ram_rd_data)
        begin
            ups_next = ups_reg + 3'd1;
        end
    end

    always_comb
    begin
        thr_low_next  = thr_low_reg;
        thr_mid_next  = thr_mid_reg;
        thr_high_next = thr_high_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_THR_LOW:  thr_low_next = cfg_data;
                CFG_THR_MID:  thr_mid_next = cfg_data;
                CFG_THR_HIGH: thr_high_next = cfg_data;
                default:      thr_low_next = thr_low_reg;
            endcase
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (cmd.update && in_range_reg && (new_spin != own_reg))
        begin
            total_next = new_spin ? total_reg + MAG_STEP : total_reg - MAG_STEP;
        end
    end

    assign clr_addr_next = cmd.clr_step ? clr_addr_reg + ADDR_W'(1) : clr_addr_reg;
    assign m_tvalid_next = cmd.push ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low_reg  <= THR_RESET;
            thr_mid_reg  <= THR_RESET;
            thr_high_reg <= THR_RESET;
            total_reg    <= MAG_RESET;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            thr_low_reg  <= thr_low_next;
            thr_mid_reg  <= thr_mid_next;
            thr_high_reg <= thr_high_next;
            total_reg    <= total_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_vld_reg   <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        ups_reg <= ups_next;
        if (cmd.load)
        begin
            req_reg      <= s_tuser;
            site_reg     <= s_tdata[SITE_W-1:0];
            val_reg      <= s_tdata[SITE_W];
            rnd_reg      <= s_tdata[SITE_W+RND_W:SITE_W+1] & RND_MASK;
            in_range_reg <= 32'(s_tdata[SITE_W-1:0]) < 32'(SITE_COUNT);
        end
        if (cmd.div)
        begin
            y_reg <= YW'(row_prod >> DIV_SHIFT);
        end
        if (cmd.coord)
        begin
            x_reg <= XW'(site_reg - row_base);
        end
        if (cmd.rd_en)
        begin
            rd_tag_reg <= cmd.rd_sel;
        end
        if (rd_vld_reg && (rd_tag_reg == SEL_SELF))
        begin
            own_reg <= ram_rd_data;
        end
        if (cmd.update)
        begin
            res_spin_reg <= in_range_reg && new_spin;
            res_flip_reg <= in_range_reg && do_flip;
        end
        if (cmd.push)
        begin
            out_spin_reg <= res_spin_reg;
            out_flip_reg <= res_flip_reg;
            out_mag_reg  <= total_reg;
        end
    end

    assign status.in_range = in_range_reg;
    assign status.is_trial = is_trial;
    assign status.clr_done = (clr_addr_reg == ADDR_W'(SITE_COUNT - 1));
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - MAG_W - 2){1'b0}}, out_mag_reg, out_flip_reg, out_spin_reg};

endmodule
`default_nettype wire

### rtl/itm_checker.sv
// Port-level checker for the Ising Metropolis block and its bind to the top level.
`default_nettype none
module itm_checker
    import itm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    localparam logic MAG_PARITY = 1'(SITE_COUNT % 2);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one request is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while one is in flight");

    // No result can appear the cycle right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // Spins change the total in steps of two, so its parity is fixed by the site count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2] == MAG_PARITY)
        else $error("magnetization parity broken");

endmodule

bind ising_triangular_metropolis itm_checker u_checker (.*);
`default_nettype wire

### bench/ising_result_checker.sv
// Checker for the triangular Ising Metropolis block: predicts every result and compares it.
`timescale 1ns / 1ps
module ising_result_checker
    import itm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,   // site[9:0], spin_value[10], random_u[26:11]
    input  wire logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_DATA_W-1:0]  m_tdata,   // site_spin[0], flipped[1], magnetization[13:2]
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]     cfg_data,
    output int                        mismatch_count,
    output int                        results_owed,
    output int                        trial_count,
    output int                        flip_count
);

    typedef struct packed {
        logic             site_spin;
        logic             flipped;
        logic [MAG_W-1:0] magnetization;
    } site_result_t;

    logic             spin_up [SITE_COUNT];
    int               spin_sum;
    logic [THR_W-1:0] thr_low;
    logic [THR_W-1:0] thr_mid;
    logic [THR_W-1:0] thr_high;
    site_result_t     owed_results [$];
    int               n_mismatch;
    int               n_trials;
    int               n_flips;

    function automatic int spin_pm(int idx);
        return spin_up[ADDR_W'(idx)] ? 1 : -1;
    endfunction

    function automatic void set_spin(int idx, logic up);
        if (spin_up[ADDR_W'(idx)] != up)
        begin
            spin_sum    = spin_sum + (up ? 2 : -2);
            spin_up[ADDR_W'(idx)] = up;
        end
    endfunction

    // Applies one request to the local lattice copy and returns the result it must give.
    function automatic site_result_t metropolis_update(logic [REQ_W-1:0] kind,
                                                       logic [SITE_W-1:0] site,
                                                       logic value,
                                                       logic [RND_W-1:0] rnd_raw);
        site_result_t     r;
        int               x;
        int               y;
        int               xl;
        int               xr;
        int               yu;
        int               yd;
        int               p;
        logic [RND_W-1:0] rnd;
        logic             flip;
        r   = '0;
        rnd = rnd_raw & RND_MASK;
        if (int'(site) < SITE_COUNT)
        begin
            if (kind == REQ_WRITE)
            begin
                set_spin(int'(site), value);
            end
            else if (kind == REQ_TRIAL)
            begin
                x  = int'(site) % LAT_W;
                y  = int'(site) / LAT_W;
                xl = (x == 0) ? LAT_W - 1 : x - 1;
                xr = (x == LAT_W - 1) ? 0 : x + 1;
                yu = (y == 0) ? LAT_H - 1 : y - 1;
                yd = (y == LAT_H - 1) ? 0 : y + 1;
                p  = spin_pm(int'(site)) * (spin_pm(xl + LAT_W * y) + spin_pm(xr + LAT_W * y) +
                                      spin_pm(x + LAT_W * yu) + spin_pm(x + LAT_W * yd) +
                                      spin_pm(xl + LAT_W * yu) + spin_pm(xr + LAT_W * yd));
                // A move that does not raise the energy is always taken.
                if (p <= 0)
                    flip = 1'b1;
                else if (p == 2)
                    flip = {1'b0, rnd} < thr_low;
                else if (p == 4)
                    flip = {1'b0, rnd} < thr_mid;
                else
                    flip = {1'b0, rnd} < thr_high;
                n_trials++;
                if (flip)
                begin
                    set_spin(int'(site), !spin_up[site]);
                    r.flipped = 1'b1;
                    n_flips++;
                end
            end
            r.site_spin = spin_up[site];
        end
        r.magnetization = MAG_W'(spin_sum);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        site_result_t got;
        site_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SITE_COUNT; i++)
                spin_up[ADDR_W'(i)] = 1'b1;
            spin_sum = SITE_COUNT;
            thr_low  = THR_RESET;
            thr_mid  = THR_RESET;
            thr_high = THR_RESET;
            owed_results.delete();
            n_mismatch = 0;
            n_trials   = 0;
            n_flips    = 0;
            mismatch_count <= 0;
            results_owed   <= 0;
            trial_count    <= 0;
            flip_count     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THR_LOW:  thr_low  = cfg_data;
                    CFG_THR_MID:  thr_mid  = cfg_data;
                    CFG_THR_HIGH: thr_high = cfg_data;
                    default:      ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.site_spin     = m_tdata[0];
                got.flipped       = m_tdata[1];
                got.magnetization = m_tdata[2 +: MAG_W];
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result 0x%0h arrived with no request outstanding",
                             $time, m_tdata);
                    n_mismatch++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.site_spin !== want.site_spin)
                    begin
                        $display("%0t: site_spin expected %0d actual %0d",
                                 $time, want.site_spin, got.site_spin);
                        n_mismatch++;
                    end
                    if (got.flipped !== want.flipped)
                    begin
                        $display("%0t: flipped expected %0d actual %0d",
                                 $time, want.flipped, got.flipped);
                        n_mismatch++;
                    end
                    if (got.magnetization !== want.magnetization)
                    begin
                        $display("%0t: magnetization expected %0d actual %0d", $time,
                                 $signed(want.magnetization), $signed(got.magnetization));
                        n_mismatch++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(metropolis_update(s_tuser, s_tdata[SITE_W-1:0],
                                                         s_tdata[SITE_W],
                                                         s_tdata[SITE_W+1 +: RND_W]));
            mismatch_count <= n_mismatch;
            results_owed   <= owed_results.size();
            trial_count    <= n_trials;
            flip_count     <= n_flips;
        end
    end

endmodule

### bench/tb_ising_triangular_metropolis.sv
// Testbench top for the triangular Ising Metropolis block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_ising_triangular_metropolis;
    import itm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int DX [7] = '{0, -1, 1, 0, 0, -1, 1};
    localparam int DY [7] = '{0, 0, 0, -1, 1, -1, 1};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [THR_W-1:0]     cfg_data = '0;

    int mismatch_count;
    int results_owed;
    int trial_count;
    int flip_count;
    int requests_sent = 0;
    bit idle_on = 1'b1;
    bit long_hold = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ising_triangular_metropolis dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ising_result_checker result_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .trial_count    (trial_count),
        .flip_count     (flip_count)
    );

    function automatic int wrap_site(int x, int y);
        return ((x + LAT_W) % LAT_W) + LAT_W * ((y + LAT_H) % LAT_H);
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] kind, input int site,
                                input logic value, input logic [RND_W-1:0] rnd);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_DATA_W'({rnd, value, SITE_W'(site)});
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    // The owed count is registered, so look at it only once it has taken up the last request.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [THR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] mid,
                                  input logic [THR_W-1:0] hi);
        wait_idle();
        write_reg(CFG_THR_LOW, lo);
        write_reg(CFG_THR_MID, mid);
        write_reg(CFG_THR_HIGH, hi);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin : result_sink
        int hold;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 200; hold++)
                    @(posedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int               phase;
        int               in_phase;
        int               bias;
        int               tx;
        int               ty;
        int               burst;
        int               pick;
        logic [THR_W-1:0] lvl [3];
        logic [RND_W-1:0] rnd;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Thresholds at reset: every trial flips, even the costliest one.
        send_request(REQ_READ, 0, 1'b0, 16'h0000);
        send_request(REQ_TRIAL, 0, 1'b0, 16'hFFFF);
        send_request(REQ_WRITE, 1023, 1'b0, 16'h5A5A);
        send_request(REQ_WRITE, 1023, 1'b0, 16'hA5A5);
        send_request(REQ_UNUSED, 1023, 1'b1, 16'h1234);
        send_request(REQ_TRIAL, 1023, 1'b1, 16'h0000);

        // Zero thresholds: no uphill move is ever taken.
        set_thresholds(17'd0, 17'd0, 17'd0);
        send_request(REQ_TRIAL, 500, 1'b0, 16'h0000);
        send_request(REQ_WRITE, 101, 1'b0, 16'h0000);
        send_request(REQ_TRIAL, 100, 1'b0, 16'h0000);

        // Random value just below and at each threshold, plus flat and downhill moves.
        set_thresholds(17'd100, 17'd65535, 17'd1);
        send_request(REQ_TRIAL, 100, 1'b0, 16'd65534);
        send_request(REQ_WRITE, 100, 1'b1, 16'h0000);
        send_request(REQ_TRIAL, 100, 1'b0, 16'd65535);
        send_request(REQ_WRITE, 99, 1'b0, 16'h0000);
        send_request(REQ_TRIAL, 100, 1'b0, 16'd99);
        send_request(REQ_WRITE, 100, 1'b1, 16'h0000);
        send_request(REQ_TRIAL, 100, 1'b0, 16'd100);
        send_request(REQ_TRIAL, 600, 1'b0, 16'd0);
        send_request(REQ_TRIAL, 600, 1'b0, 16'hFFFF);
        send_request(REQ_WRITE, 68, 1'b0, 16'h0000);
        send_request(REQ_TRIAL, 100, 1'b1, 16'hFFFF);
        send_request(REQ_TRIAL, 31, 1'b1, 16'h8000);
        send_request(REQ_TRIAL, 992, 1'b0, 16'h7FFF);
        send_request(REQ_READ, 1023, 1'b1, 16'hFFFF);

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                1:
                begin
                    lvl[0] = 17'd65536;
                    lvl[1] = 17'd65536;
                    lvl[2] = 17'd65536;
                end
                2:
                begin
                    lvl[0] = 17'd0;
                    lvl[1] = 17'd0;
                    lvl[2] = 17'd0;
                end
                3:
                begin
                    lvl[0] = 17'h1FFFF;
                    lvl[1] = 17'd1;
                    lvl[2] = 17'd65535;
                end
                5:
                begin
                    lvl[0] = 17'd32768;
                    lvl[1] = 17'd8192;
                    lvl[2] = 17'd1024;
                end
                default:
                begin
                    lvl[0] = THR_W'($urandom_range(0, 65536));
                    lvl[1] = THR_W'($urandom_range(0, 65536));
                    lvl[2] = THR_W'($urandom_range(0, 65536));
                end
            endcase
            set_thresholds(lvl[0], lvl[1], lvl[2]);
            if (phase == 1)
                long_hold = 1'b1;
            in_phase = 0;
            while (in_phase < 115)
            begin
                idle_on = (phase != 7) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 3) == 0)
                begin
                    burst = $urandom_range(1, 6);
                    repeat (burst)
                        send_request(REQ_W'($urandom_range(0, 3)),
                                     $urandom_range(0, SITE_COUNT - 1),
                                     1'($urandom_range(0, 1)), RND_W'($urandom()));
                    in_phase += burst;
                end
                else
                begin
                    // Set the site and, mostly, its six neighbors with a chosen bias, then try a flip.
                    tx   = $urandom_range(0, LAT_W - 1);
                    ty   = $urandom_range(0, LAT_H - 1);
                    bias = $urandom_range(0, 4);
                    for (int k = 0; k < 7; k++)
                    begin
                        if (k == 0 || $urandom_range(0, 7) != 0)
                        begin
                            send_request(REQ_WRITE,
                                         wrap_site(tx + DX[3'(k)], ty + DY[3'(k)]),
                                         (k == 0) ? 1'($urandom_range(0, 1))
                                                  : ($urandom_range(0, 3) < bias),
                                         RND_W'($urandom()));
                            in_phase++;
                        end
                    end
                    pick = $urandom_range(0, 2);
                    case ($urandom_range(0, 3))
                        0:       rnd = RND_W'($urandom());
                        1:       rnd = RND_W'(lvl[2'(pick)]);
                        2:       rnd = RND_W'(lvl[2'(pick)] - 17'd1);
                        default: rnd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    endcase
                    send_request(REQ_TRIAL, wrap_site(tx, ty), 1'($urandom_range(0, 1)), rnd);
                    in_phase++;
                    if ($urandom_range(0, 9) < 3)
                    begin
                        send_request(REQ_TRIAL, wrap_site(tx, ty), 1'b0, RND_W'($urandom()));
                        in_phase++;
                    end
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_request($urandom_range(0, 1) ? REQ_READ : REQ_UNUSED,
                                     wrap_site(tx, ty), 1'($urandom_range(0, 1)),
                                     RND_W'($urandom()));
                        in_phase++;
                    end
                end
            end
        end

        idle_on = 1'b0;
        wait_idle();
        repeat (20) @(posedge clk);
        $display("Run covered %0d requests over eleven threshold settings.", requests_sent);
        $display("Flip trials: %0d, of which %0d flipped the spin.", trial_count, flip_count);
        if (mismatch_count == 0)
            $display("PASS ising_triangular_metropolis");
        else
            $display("FAIL ising_triangular_metropolis");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Timed out with %0d results still owed.", results_owed);
        $display("FAIL ising_triangular_metropolis");
        $finish;
    end

endmodule
